>>> sv/bpa_pkg.sv
// shared widths, codes and result type of the block pool allocator
`default_nettype none

package bpa_pkg;

    localparam int SIZE_W    = 32;
    localparam int IDX_W     = 6;
    localparam int OFS_OUT_W = 28;
    localparam int ALIGN_W   = 5;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = SIZE_W + 1;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 5'd8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_REUSE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd2;
    localparam logic [STAT_W-1:0] ST_FREED   = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [IDX_W-1:0]     block_number;
        logic [OFS_OUT_W-1:0] block_offset;
        logic                 bad_index;
    } t_result;

endpackage

`default_nettype wire

>>> sv/bpa_if.sv
// handshake channels of the block pool allocator
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [SIZE_W-1:0]  request_size;
    logic [IDX_W-1:0]   free_index;

    modport source (output valid, operation, request_size, free_index, input ready);
    modport sink   (input valid, operation, request_size, free_index, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     block_number;
    logic [OFS_OUT_W-1:0] block_offset;
    logic                 bad_index;

    modport source (output valid, status, block_number, block_offset, bad_index,
                    input ready);
    modport sink   (input valid, status, block_number, block_offset, bad_index,
                    output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ALIGN_W-1:0] alignment_log2;

    modport source (output valid, alignment_log2, input ready);
    modport sink   (input valid, alignment_log2, output ready);
endinterface

`default_nettype wire

>>> sv/bpa_table.sv
// block table memory: one write port, one registered read port
`default_nettype none

module bpa_table #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/block_pool_allocator.sv
// block pool allocator top level: sequencer, freed mask and result register
//
//  channel   dir  payload                                            transaction
//  i_req     in   operation, request_size, free_index                valid & ready
//  o_rsp     out  status, block_number, block_offset, bad_index      valid & ready
//  i_cfg     in   alignment_log2                                     valid & ready
//
// allocate: table scan, one entry read per cycle over the allocated entries, then a new-block
//   check if no freed entry fits; a free reads its entry as the transaction is taken
// the single read port of the table memory sets the scan length
// next transaction is taken the cycle after a result loads, even while it waits in o_rsp
// a stalled o_rsp holds the next finished result in the done state
// reset clears block count, pool end and freed mask and sets alignment_log2 to 8; no clearing pass
`default_nettype none

module block_pool_allocator
    import bpa_pkg::*;
#(
    parameter int POOL_BYTES = 268435456,
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp,
    bpa_cfg_if.sink   i_cfg
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int OFS_W = $clog2(POOL_BYTES);
    localparam int END_W = $clog2(POOL_BYTES + 1);
    localparam int ENT_W = OFS_W + END_W;
    localparam int SUM_W = CAP_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [ALIGN_W-1:0]    r_align, n_align;
    logic [CW-1:0]         r_count, n_count;
    logic [END_W-1:0]      r_pool_end, n_pool_end;
    logic [MAX_BLOCKS-1:0] r_freed, n_freed;
    logic [CW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_raddr, n_raddr;
    logic                  r_rvld, n_rvld;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [IDX_W-1:0]      r_index, n_index;
    logic [CAP_W-1:0]      r_cap, n_cap;
    t_result               r_res, n_res;
    t_result               r_out, n_out;
    logic                  r_ovld, n_ovld;

    logic                  req_fire;
    logic                  out_free;
    logic                  issue;
    logic                  hit;
    logic                  bad;
    logic                  no_room;
    logic [CAP_W-1:0]      align_mask;
    logic [CAP_W-1:0]      size_sum;
    logic [SUM_W-1:0]      end_sum;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [ENT_W-1:0]      mem_wdata;
    logic [ENT_W-1:0]      mem_rdata;
    logic [OFS_W-1:0]      ent_ofs;
    logic [END_W-1:0]      ent_cap;

    bpa_table #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_ovld || o_rsp.ready;

    assign o_rsp.valid        = r_ovld;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.block_number = r_out.block_number;
    assign o_rsp.block_offset = r_out.block_offset;
    assign o_rsp.bad_index    = r_out.bad_index;

    assign {ent_ofs, ent_cap} = mem_rdata;

    // round the request up to the alignment
    assign align_mask = (CAP_W'(1) << r_align) - CAP_W'(1);
    assign size_sum   = CAP_W'(r_size) + align_mask;
    assign end_sum    = SUM_W'(r_pool_end) + SUM_W'(r_cap);

    assign issue   = (r_state == S_SCAN) && (r_addr < r_count);
    assign hit     = r_rvld && r_freed[r_raddr] && (CAP_W'(ent_cap) >= CAP_W'(r_size));
    assign bad     = (7'(r_index) >= 7'(r_count));
    assign no_room = (r_count >= CW'(MAX_BLOCKS))
                  || (r_pool_end >= END_W'(POOL_BYTES))
                  || (end_sum > SUM_W'(POOL_BYTES));

    assign mem_we    = (r_state == S_CHECK) && !no_room;
    assign mem_wdata = {r_pool_end[OFS_W-1:0], r_cap[END_W-1:0]};
    assign mem_re    = (req_fire && (i_req.operation == OP_FREE)) || issue;
    assign mem_raddr = (r_state == S_SCAN) ? r_addr[AW-1:0] : i_req.free_index[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_align    = r_align;
        n_count    = r_count;
        n_pool_end = r_pool_end;
        n_freed    = r_freed;
        n_addr     = r_addr;
        n_raddr    = r_raddr;
        n_rvld     = 1'b0;
        n_size     = r_size;
        n_index    = r_index;
        n_cap      = r_cap;
        n_res      = r_res;
        n_out      = r_out;
        n_ovld     = r_ovld && !o_rsp.ready;

        if (i_cfg.valid && i_cfg.ready) begin
            n_align = i_cfg.alignment_log2;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_size  = i_req.request_size;
                    n_index = i_req.free_index;
                    n_addr  = '0;
                    n_state = (i_req.operation == OP_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                n_cap = size_sum & ~align_mask;
                if (issue) begin
                    n_raddr = r_addr[AW-1:0];
                    n_rvld  = 1'b1;
                    n_addr  = r_addr + CW'(1);
                end
                if (hit) begin
                    n_freed[r_raddr]    = 1'b0;
                    n_res.status        = ST_REUSE;
                    n_res.block_number  = IDX_W'(r_raddr);
                    n_res.block_offset  = OFS_OUT_W'(ent_ofs);
                    n_res.bad_index     = 1'b0;
                    n_state             = S_DONE;
                end else if (!r_rvld && !issue) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (no_room) begin
                    n_res.status       = ST_NO_ROOM;
                    n_res.block_number = '0;
                    n_res.block_offset = '0;
                end else begin
                    n_res.status       = ST_NEW;
                    n_res.block_number = IDX_W'(r_count);
                    n_res.block_offset = OFS_OUT_W'(r_pool_end[OFS_W-1:0]);
                    n_pool_end         = END_W'(end_sum);
                    n_count            = r_count + CW'(1);
                end
                n_res.bad_index = 1'b0;
                n_state         = S_DONE;
            end
            S_FREE: begin
                n_res.status = ST_FREED;
                if (bad) begin
                    n_res.block_number = '0;
                    n_res.block_offset = '0;
                    n_res.bad_index    = 1'b1;
                end else begin
                    n_freed[r_index[AW-1:0]] = 1'b1;
                    n_res.block_number       = r_index;
                    n_res.block_offset       = OFS_OUT_W'(ent_ofs);
                    n_res.bad_index          = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out   = r_res;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_align    <= ALIGN_RESET;
            r_count    <= '0;
            r_pool_end <= '0;
            r_freed    <= '0;
            r_rvld     <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_align    <= n_align;
            r_count    <= n_count;
            r_pool_end <= n_pool_end;
            r_freed    <= n_freed;
            r_rvld     <= n_rvld;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_raddr <= n_raddr;
        r_size  <= n_size;
        r_index <= n_index;
        r_cap   <= n_cap;
        r_res   <= n_res;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_end_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_end <= END_W'(POOL_BYTES))
        else $error("pool end beyond pool size");

    a_freed_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_freed >> r_count) == '0)
        else $error("freed bit set for a block never allocated");

    a_end_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_pool_end >= $past(r_pool_end))
        else $error("pool end moved backward");

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bad_index) |-> (o_rsp.status == ST_FREED
            && o_rsp.block_number == '0 && o_rsp.block_offset == '0))
        else $error("bad index result carries block data");
`endif

endmodule

`default_nettype wire
